@@ sv/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg: shared constants, types and helpers for the radial spotlight dimmer
// Fixed-point formats, pipeline sizing and the square-root digit step.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Fixed-point and field sizing
  localparam int FRAC_BITS   = 16;
  localparam int MAX_DIM     = 4096;
  localparam int COORD_W     = 12;
  localparam int CFG_W       = 14;
  localparam int CHAN_W      = 8;
  localparam int DIFF_W      = CFG_W + 1;
  localparam int ABS_W       = CFG_W;

  // Falloff: factor reaches zero at this distance
  localparam int FALLOFF_DIV = 200;
  localparam int FAR_SQ      = FALLOFF_DIV * FALLOFF_DIV;
  localparam int NEAR_W      = $clog2(FALLOFF_DIV);
  localparam int SQ_W        = 2 * NEAR_W;
  localparam int SQ_SUM_W    = SQ_W + 1;

  // Square root of sq << (2*FRAC_BITS), two result bits per stage
  localparam int ROOT_W         = SQ_W / 2 + FRAC_BITS;
  localparam int REM_W          = ROOT_W + 3;
  localparam int SQRT_IN_W      = SQ_W + 2 * FRAC_BITS;
  localparam int BITS_PER_STAGE = 2;
  localparam int SQRT_STAGES    = ROOT_W / BITS_PER_STAGE;

  // Divide by FALLOFF_DIV through a reciprocal multiply, exact for ROOT_W-bit values
  localparam int DROP_SHIFT = ROOT_W + NEAR_W;
  localparam int MULT_W     = DROP_SHIFT - NEAR_W + 1;
  localparam int PROD_W     = ROOT_W + MULT_W;
  localparam int FACT_W     = FRAC_BITS + 1;
  localparam logic [MULT_W-1:0] DROP_MULT =
    MULT_W'(((64'd1 << DROP_SHIFT) + 64'(FALLOFF_DIV) - 64'd1) / 64'(FALLOFF_DIV));
  localparam logic [FACT_W-1:0] ONE = FACT_W'(1) << FRAC_BITS;

  typedef enum logic [0:0] {
    REG_CENTER_X = 1'b0,
    REG_CENTER_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_rgb_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_acc_t;

  // One restoring digit step: bring in two radicand bits, try 4q+1.
  function automatic root_acc_t sqrt_step(root_acc_t acc, logic [1:0] pair);
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    root_acc_t        res;
    rem_sh = {acc.rem[REM_W-3:0], pair};
    trial  = {1'b0, acc.root, 2'b01};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ sv/radial_spotlight_dimmer_core.sv @@
// ----------------------------------------------------------------------------
// radial_spotlight_dimmer_core: radial vignette with linear falloff
// Darkens each RGB pixel by its distance from a programmable center.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while in_stall is low and returns one
// dimmed pixel per input, in order, through registered stages for the
// coordinate differences, the squares, the square root (two result bits
// per stage over a 24-bit root), the divide by 200, the factor and the
// channel multiplies, in that order. Throughput is one beat per
// clock while out_stall stays low. A two-entry output (last stage plus a skid
// register) lets the pipeline take one more beat when the consumer stalls;
// after that in_stall rises until the skid register drains. The factor is
// 1 - d/200 in Q1.16, so pixels 200 or more away from the center come out
// black and a pixel on the center passes unchanged. Write center_x (index 0)
// and center_y (index 1) only while the pipeline is empty; cfg_ready is
// always high.
module radial_spotlight_dimmer_core (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [0:0]                  cfg_index,
  input  logic [rsd_pkg::CFG_W-1:0]   cfg_data,
  // input pixel channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rsd_pkg::COORD_W-1:0] pixel_x,
  input  logic [rsd_pkg::COORD_W-1:0] pixel_y,
  input  logic [rsd_pkg::CHAN_W-1:0]  in_red,
  input  logic [rsd_pkg::CHAN_W-1:0]  in_green,
  input  logic [rsd_pkg::CHAN_W-1:0]  in_blue,
  // output pixel channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rsd_pkg::CHAN_W-1:0]  out_red,
  output logic [rsd_pkg::CHAN_W-1:0]  out_green,
  output logic [rsd_pkg::CHAN_W-1:0]  out_blue
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rsd_pkg::CFG_W-1:0] center_x;
  logic [rsd_pkg::CFG_W-1:0] center_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rsd_pkg::cfg_reg_t'(cfg_index))
        rsd_pkg::REG_CENTER_X: center_x <= cfg_data;
        rsd_pkg::REG_CENTER_Y: center_y <= cfg_data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid register holds
  // a beat. The skid catches the last stage when the consumer stalls.
  // --------------------------------------------------------------------------
  logic sk_valid;
  logic adv;

  assign adv      = !sk_valid;
  assign in_stall = sk_valid;

  // --------------------------------------------------------------------------
  // Stage 1: clamp coordinates, signed differences, absolute values.
  // A difference of 200 or more on either axis already means black.
  // --------------------------------------------------------------------------
  logic [rsd_pkg::COORD_W-1:0] px_c;
  logic [rsd_pkg::COORD_W-1:0] py_c;
  logic [rsd_pkg::DIFF_W-1:0]  dx;
  logic [rsd_pkg::DIFF_W-1:0]  dy;
  logic [rsd_pkg::DIFF_W-1:0]  dx_mag;
  logic [rsd_pkg::DIFF_W-1:0]  dy_mag;
  logic [rsd_pkg::ABS_W-1:0]   adx;
  logic [rsd_pkg::ABS_W-1:0]   ady;
  logic                        near_xy;

  always_comb begin
    px_c = ({1'b0, pixel_x} >= (rsd_pkg::COORD_W + 1)'(rsd_pkg::MAX_DIM)) ?
           rsd_pkg::COORD_W'(rsd_pkg::MAX_DIM - 1) : pixel_x;
    py_c = ({1'b0, pixel_y} >= (rsd_pkg::COORD_W + 1)'(rsd_pkg::MAX_DIM)) ?
           rsd_pkg::COORD_W'(rsd_pkg::MAX_DIM - 1) : pixel_y;
    // pixel minus sign-extended center, in two's complement
    dx = {(rsd_pkg::DIFF_W - rsd_pkg::COORD_W)'(0), px_c}
         - {center_x[rsd_pkg::CFG_W-1], center_x};
    dy = {(rsd_pkg::DIFF_W - rsd_pkg::COORD_W)'(0), py_c}
         - {center_y[rsd_pkg::CFG_W-1], center_y};
    dx_mag = dx[rsd_pkg::DIFF_W-1] ? (~dx + 1'b1) : dx;
    dy_mag = dy[rsd_pkg::DIFF_W-1] ? (~dy + 1'b1) : dy;
    adx = dx_mag[rsd_pkg::ABS_W-1:0];
    ady = dy_mag[rsd_pkg::ABS_W-1:0];
    near_xy = (adx < rsd_pkg::ABS_W'(rsd_pkg::FALLOFF_DIV)) &&
              (ady < rsd_pkg::ABS_W'(rsd_pkg::FALLOFF_DIV));
  end

  logic                       s1_valid;
  logic                       s1_near;
  logic [rsd_pkg::NEAR_W-1:0] s1_dx;
  logic [rsd_pkg::NEAR_W-1:0] s1_dy;
  rsd_pkg::pixel_rgb_t        s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_near <= near_xy;
      s1_dx   <= adx[rsd_pkg::NEAR_W-1:0];
      s1_dy   <= ady[rsd_pkg::NEAR_W-1:0];
      s1_pix  <= '{red: in_red, green: in_green, blue: in_blue};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: squared distance; anything at or past the falloff edge is far.
  // --------------------------------------------------------------------------
  logic [rsd_pkg::SQ_W-1:0]     sq_x;
  logic [rsd_pkg::SQ_W-1:0]     sq_y;
  logic [rsd_pkg::SQ_SUM_W-1:0] sq_sum;

  assign sq_x   = rsd_pkg::SQ_W'(s1_dx) * rsd_pkg::SQ_W'(s1_dx);
  assign sq_y   = rsd_pkg::SQ_W'(s1_dy) * rsd_pkg::SQ_W'(s1_dy);
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

  logic                     s2_valid;
  logic                     s2_near;
  logic [rsd_pkg::SQ_W-1:0] s2_sq;
  rsd_pkg::pixel_rgb_t      s2_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_near <= s1_near && (sq_sum < rsd_pkg::SQ_SUM_W'(rsd_pkg::FAR_SQ));
      s2_sq   <= sq_sum[rsd_pkg::SQ_W-1:0];
      s2_pix  <= s1_pix;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root pipeline: root of sq << (2*FRAC_BITS), distance in Q16.
  // Each stage retires two root bits; the radicand's low half is all zero.
  // --------------------------------------------------------------------------
  logic                     rt_valid [rsd_pkg::SQRT_STAGES];
  logic                     rt_near  [rsd_pkg::SQRT_STAGES];
  logic [rsd_pkg::SQ_W-1:0] rt_sq    [rsd_pkg::SQRT_STAGES];
  rsd_pkg::root_acc_t       rt_acc   [rsd_pkg::SQRT_STAGES];
  rsd_pkg::pixel_rgb_t      rt_pix   [rsd_pkg::SQRT_STAGES];

  for (genvar g = 0; g < rsd_pkg::SQRT_STAGES; g++) begin : g_sqrt
    logic                          st_valid;
    logic                          st_near;
    logic [rsd_pkg::SQ_W-1:0]      st_sq;
    rsd_pkg::root_acc_t            st_acc;
    rsd_pkg::pixel_rgb_t           st_pix;
    logic [rsd_pkg::SQRT_IN_W-1:0] rad;
    rsd_pkg::root_acc_t            acc_next;

    if (g == 0) begin : g_first
      assign st_valid = s2_valid;
      assign st_near  = s2_near;
      assign st_sq    = s2_sq;
      assign st_acc   = '0;
      assign st_pix   = s2_pix;
    end else begin : g_rest
      assign st_valid = rt_valid[g-1];
      assign st_near  = rt_near[g-1];
      assign st_sq    = rt_sq[g-1];
      assign st_acc   = rt_acc[g-1];
      assign st_pix   = rt_pix[g-1];
    end

    assign rad = {st_sq, (2 * rsd_pkg::FRAC_BITS)'(0)};

    always_comb begin
      acc_next = st_acc;
      for (int t = 0; t < rsd_pkg::BITS_PER_STAGE; t++) begin
        acc_next = rsd_pkg::sqrt_step(acc_next,
          rad[rsd_pkg::SQRT_IN_W - 1 - 2 * (g * rsd_pkg::BITS_PER_STAGE + t) -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_valid[g] <= 1'b0;
      end else if (adv) begin
        rt_valid[g] <= st_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_near[g] <= st_near;
        rt_sq[g]   <= st_sq;
        rt_acc[g]  <= acc_next;
        rt_pix[g]  <= st_pix;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drop stage: floor(distance / 200) by reciprocal multiply.
  // --------------------------------------------------------------------------
  localparam int LAST = rsd_pkg::SQRT_STAGES - 1;

  logic [rsd_pkg::PROD_W-1:0] drop_prod;

  assign drop_prod = rsd_pkg::PROD_W'(rt_acc[LAST].root)
                     * rsd_pkg::PROD_W'(rsd_pkg::DROP_MULT);

  logic                       dp_valid;
  logic                       dp_near;
  logic [rsd_pkg::FACT_W-1:0] dp_drop;
  rsd_pkg::pixel_rgb_t        dp_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_valid <= 1'b0;
    end else if (adv) begin
      dp_valid <= rt_valid[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp_near <= rt_near[LAST];
      dp_drop <= drop_prod[rsd_pkg::DROP_SHIFT +: rsd_pkg::FACT_W];
      dp_pix  <= rt_pix[LAST];
    end
  end

  // --------------------------------------------------------------------------
  // Factor stage: 1.0 minus the drop, zero for far pixels.
  // --------------------------------------------------------------------------
  logic [rsd_pkg::FACT_W-1:0] factor;

  always_comb begin
    if (dp_near && (dp_drop < rsd_pkg::ONE)) begin
      factor = rsd_pkg::ONE - dp_drop;
    end else begin
      factor = '0;
    end
  end

  logic                       fc_valid;
  logic [rsd_pkg::FACT_W-1:0] fc_factor;
  rsd_pkg::pixel_rgb_t        fc_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      fc_valid <= 1'b0;
    end else if (adv) begin
      fc_valid <= dp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fc_factor <= factor;
      fc_pix    <= dp_pix;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: scale each channel and drop the fraction bits.
  // --------------------------------------------------------------------------
  localparam int MUL_W = rsd_pkg::CHAN_W + rsd_pkg::FACT_W;

  logic [MUL_W-1:0]    mul_r;
  logic [MUL_W-1:0]    mul_g;
  logic [MUL_W-1:0]    mul_b;
  rsd_pkg::pixel_rgb_t scaled;

  assign mul_r  = MUL_W'(fc_pix.red)   * MUL_W'(fc_factor);
  assign mul_g  = MUL_W'(fc_pix.green) * MUL_W'(fc_factor);
  assign mul_b  = MUL_W'(fc_pix.blue)  * MUL_W'(fc_factor);
  assign scaled = '{red:   mul_r[rsd_pkg::FRAC_BITS +: rsd_pkg::CHAN_W],
                    green: mul_g[rsd_pkg::FRAC_BITS +: rsd_pkg::CHAN_W],
                    blue:  mul_b[rsd_pkg::FRAC_BITS +: rsd_pkg::CHAN_W]};

  logic                o_valid;
  rsd_pkg::pixel_rgb_t o_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= fc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pix <= scaled;
    end
  end

  // --------------------------------------------------------------------------
  // Skid register: capture the last stage when the consumer stalls, drain it
  // first once the stall drops. The presented beat never changes while held.
  // --------------------------------------------------------------------------
  rsd_pkg::pixel_rgb_t sk_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_valid <= 1'b0;
    end else if (!sk_valid) begin
      sk_valid <= o_valid && out_stall;
    end else if (!out_stall) begin
      sk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid) begin
      sk_pix <= o_pix;
    end
  end

  assign out_valid = sk_valid || o_valid;
  assign out_red   = sk_valid ? sk_pix.red   : o_pix.red;
  assign out_green = sk_valid ? sk_pix.green : o_pix.green;
  assign out_blue  = sk_valid ? sk_pix.blue  : o_pix.blue;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radial spotlight dimmer
// Drives pixels and center writes under random pacing on both channels and
// checks each pixel against a bit-exact falloff predictor or a typed answer.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;

  // Worst case is roughly 1200 beats, each behind the longest source gap and
  // the longest sink stall plus pipeline fill; the limit is several times that.
  localparam int CYCLE_LIMIT  = 600000;
  // 17 pipeline stages plus the skid entry, with margin
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 11;
  localparam int PHASE_BEATS  = 100;

  // One directed probe: center to program, pixel to send and, where the answer
  // is obvious, the dimmed pixel typed in by hand.
  typedef struct packed {
    logic signed [CFG_W-1:0] cx;
    logic signed [CFG_W-1:0] cy;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    pixel_rgb_t              rgb;
    bit                      known;
    pixel_rgb_t              known_rgb;
  } probe_row_t;

  // 14'sh2000 is the most negative center, -8192.
  localparam probe_row_t PROBE_ROWS [0:23] = '{
    // pixel on the center passes unchanged
    '{14'sd0,    14'sd0,    12'd0,    12'd0,    24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{14'sd0,    14'sd0,    12'd0,    12'd0,    24'h000000, 1'b1, 24'h000000},
    '{14'sd0,    14'sd0,    12'd0,    12'd0,    24'hAA550F, 1'b1, 24'hAA550F},
    // far corner and exactly 200 away on each axis and on a diagonal: black
    '{14'sd0,    14'sd0,    12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd0,    14'sd0,    12'd200,  12'd0,    24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd0,    14'sd0,    12'd0,    12'd200,  24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd0,    14'sd0,    12'd120,  12'd160,  24'hFFFFFF, 1'b1, 24'h000000},
    // just inside the falloff edge, and one step off the center
    '{14'sd0,    14'sd0,    12'd199,  12'd0,    24'hFFFFFF, 1'b0, 24'h000000},
    '{14'sd0,    14'sd0,    12'd1,    12'd0,    24'hFFFFFF, 1'b0, 24'h000000},
    '{14'sd0,    14'sd0,    12'd119,  12'd159,  24'h80FF01, 1'b0, 24'h000000},
    // distance 100 halves every channel; far ends of each axis go black
    '{14'sd0,    14'sd0,    12'd0,    12'd100,  24'hC86432, 1'b1, 24'h643219},
    '{14'sd0,    14'sd0,    12'd4095, 12'd0,    24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd0,    14'sd0,    12'd0,    12'd4095, 24'hFFFFFF, 1'b1, 24'h000000},
    // pixel left of and above the center must mirror the one right and below
    '{14'sd100,  14'sd100,  12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h000000},
    '{14'sd100,  14'sd100,  12'd200,  12'd200,  24'hFFFFFF, 1'b0, 24'h000000},
    '{14'sd100,  14'sd100,  12'd100,  12'd100,  24'h123456, 1'b1, 24'h123456},
    // negative centers, then large positive ones
    '{-14'sd100, 14'sd0,    12'd0,    12'd0,    24'hFF8001, 1'b1, 24'h7F4000},
    '{-14'sd1,   -14'sd1,   12'd0,    12'd0,    24'hFFFFFF, 1'b0, 24'h000000},
    '{14'sh2000, 14'sh2000, 12'd0,    12'd0,    24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd8191, 14'sd8191, 12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd4095, 14'sd4095, 12'd4095, 12'd4095, 24'hFEDCBA, 1'b1, 24'hFEDCBA},
    '{14'sh2000, 14'sd8191, 12'd0,    12'd4095, 24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd8191, 14'sh2000, 12'd4095, 12'd0,    24'hFFFFFF, 1'b1, 24'h000000},
    '{14'sd4000, 14'sd4095, 12'd4095, 12'd3900, 24'h7F7F7F, 1'b0, 24'h000000}
  };

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_CENTER_X;
  logic [CFG_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [COORD_W-1:0]  pixel_x   = '0;
  logic [COORD_W-1:0]  pixel_y   = '0;
  logic [CHAN_W-1:0]   in_red    = '0;
  logic [CHAN_W-1:0]   in_green  = '0;
  logic [CHAN_W-1:0]   in_blue   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;

  // Hand-typed answer riding along with the pixel beat it belongs to
  bit                  beat_known     = 1'b0;
  pixel_rgb_t          beat_known_rgb = '0;

  // Predictor's copy of the center registers
  logic signed [CFG_W-1:0] spot_cx = '0;
  logic signed [CFG_W-1:0] spot_cy = '0;

  pixel_rgb_t dimmed_q [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  radial_spotlight_dimmer_core dut (.*);

  always #5 clk = ~clk;

  // Floor of the square root, one result bit at a time from the top.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Dim one pixel: distance in Q16 from the squared distance, linear falloff
  // to zero at 200, then truncating multiply per channel.
  function automatic pixel_rgb_t dim_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                           logic signed [CFG_W-1:0] cx,
                                           logic signed [CFG_W-1:0] cy, pixel_rgb_t c);
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned drop;
    longint unsigned gain;
    pixel_rgb_t      o;
    // saturate coordinates at the image bound, then take signed differences
    dx = ((px >= MAX_DIM) ? longint'(MAX_DIM - 1) : longint'(px)) - longint'(cx);
    dy = ((py >= MAX_DIM) ? longint'(MAX_DIM - 1) : longint'(py)) - longint'(cy);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq   = dx * dx + dy * dy;
    gain = 0;
    if (sq < FAR_SQ) begin
      drop = floor_root(sq << (2 * FRAC_BITS)) / FALLOFF_DIV;
      gain = (drop < ONE) ? ONE - drop : 0;
    end
    o.red   = CHAN_W'((c.red   * gain) >> FRAC_BITS);
    o.green = CHAN_W'((c.green * gain) >> FRAC_BITS);
    o.blue  = CHAN_W'((c.blue  * gain) >> FRAC_BITS);
    return o;
  endfunction

  // Mostly back-to-back, sometimes a few idle cycles, rarely a long hole.
  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      6, 7, 8: return $urandom_range(1, 3);
      9:       return $urandom_range(5, 40);
      default: return 0;
    endcase
  endfunction

  // Full-scale and zero channels show up often on purpose.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Coordinate within about 220 of a center, held inside the image.
  function automatic logic [COORD_W-1:0] near_coord(logic signed [CFG_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 440)) - 220;
    if (v < 0) v = 0;
    if (v > MAX_DIM - 1) v = MAX_DIM - 1;
    return COORD_W'(v);
  endfunction

  // Present one pixel beat after an optional gap and hold it until taken.
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input pixel_rgb_t c, input bit known, input pixel_rgb_t known_rgb,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel_x        <= px;
    pixel_y        <= py;
    in_red         <= c.red;
    in_green       <= c.green;
    in_blue        <= c.blue;
    beat_known     <= known;
    beat_known_rgb <= known_rgb;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every pixel sent so far has come back, then let
  // the pipeline settle so a config write cannot land on a beat in flight.
  task automatic await_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (dimmed_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both center registers back to back; valid stays high between them.
  task automatic set_center(input logic signed [CFG_W-1:0] cx,
                            input logic signed [CFG_W-1:0] cy);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CENTER_X;
    cfg_data  <= cx;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_CENTER_Y;
    cfg_data  <= cy;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Scoreboard: everything sampled at the edge, so values are the ones the
  // DUT saw. Track config writes, predict on each accepted pixel beat and
  // compare each accepted output beat against the oldest prediction.
  always @(posedge clk) begin : score
    pixel_rgb_t got;
    pixel_rgb_t want;
    if (rst) begin
      spot_cx <= '0;
      spot_cy <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER_X: spot_cx <= cfg_data;
          REG_CENTER_Y: spot_cy <= cfg_data;
        endcase
      end
      if (in_valid && !in_stall) begin
        dimmed_q.push_back(beat_known ? beat_known_rgb :
                           dim_pixel(pixel_x, pixel_y, spot_cx, spot_cy,
                                     {in_red, in_green, in_blue}));
      end
      if (out_valid && !out_stall) begin
        got = {out_red, out_green, out_blue};
        if (dimmed_q.size() == 0) begin
          $display("%0t: unexpected output beat, expected none, got rgb %h", $time, got);
          mismatch_count++;
        end else begin
          want = dimmed_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[8*(2-i) +: 8] !== want[8*(2-i) +: 8]) begin
              $display("%0t: out_%s expected %0d, got %0d", $time,
                       (i == 0) ? "red" : (i == 1) ? "green" : "blue",
                       want[8*(2-i) +: 8], got[8*(2-i) +: 8]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // Sink pacing: free-running runs, short stalls, the odd long stall and long
  // stretches with no stall at all.
  initial begin : sink_pacing
    int run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_stall <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Give up if the run hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    probe_row_t              row;
    logic signed [CFG_W-1:0] cur_cx;
    logic signed [CFG_W-1:0] cur_cy;
    logic signed [CFG_W-1:0] nx;
    logic signed [CFG_W-1:0] ny;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    pixel_rgb_t              c;
    bit                      steady;
    cur_cx = '0;
    cur_cy = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed probes; reprogram the center only when a row asks for a new one.
    foreach (PROBE_ROWS[i]) begin
      row = PROBE_ROWS[i];
      if (row.cx != cur_cx || row.cy != cur_cy) begin
        await_idle();
        set_center(row.cx, row.cy);
        cur_cx = row.cx;
        cur_cy = row.cy;
      end
      send_pixel(row.px, row.py, row.rgb, row.known, row.known_rgb, pick_gap());
    end

    // Random phases, each under its own center. The first few pin the
    // extremes; the rest land in or just around the image.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin nx = CFG_W'(0);     ny = CFG_W'(0);     end
        1: begin nx = CFG_W'(-8192); ny = CFG_W'(-8192); end
        2: begin nx = CFG_W'(8191);  ny = CFG_W'(8191);  end
        3: begin nx = CFG_W'(4095);  ny = CFG_W'(0);     end
        4: begin nx = CFG_W'(-150);  ny = CFG_W'(4000);  end
        default: begin
          nx = CFG_W'(int'($urandom_range(0, 4600)) - 300);
          ny = CFG_W'(int'($urandom_range(0, 4600)) - 300);
        end
      endcase
      await_idle();
      set_center(nx, ny);
      // every fourth phase streams with no source gaps at all
      steady = (ph % 4 == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // now and then hold off until the pipeline has fully drained
        if ($urandom_range(0, 149) == 0) await_idle();
        // mostly near the lit disc, some anywhere, some on the image corners
        case ($urandom_range(0, 9))
          8: begin
            px = COORD_W'($urandom);
            py = COORD_W'($urandom);
          end
          9: begin
            px = $urandom_range(0, 1) ? COORD_W'(MAX_DIM - 1) : '0;
            py = $urandom_range(0, 1) ? COORD_W'(MAX_DIM - 1) : '0;
          end
          default: begin
            px = near_coord(nx);
            py = near_coord(ny);
          end
        endcase
        c.red   = rand_chan();
        c.green = rand_chan();
        c.blue  = rand_chan();
        send_pixel(px, py, c, 1'b0, '0, steady ? 0 : pick_gap());
      end
    end

    await_idle();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rsd_pkg.sv
sv/radial_spotlight_dimmer_core.sv
verif/tb_top.sv
